>>> rtl/second_order_adpcm_block_decoder_macros.svh
// Assertion macros for the second-order ADPCM block decoder.
// Included by the top level; depends on nothing else.
`ifndef SECOND_ORDER_ADPCM_BLOCK_DECODER_MACROS_SVH
`define SECOND_ORDER_ADPCM_BLOCK_DECODER_MACROS_SVH
`ifndef SYNTH
// The condition must never hold at a clock edge outside reset.
`define ADPCM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("adpcm assertion failed");
// The consequence must hold in the cycle after the antecedent.
`define ADPCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adpcm assertion failed");
// The consequence must hold in the same cycle as the antecedent.
`define ADPCM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adpcm assertion failed");
`else
`define ADPCM_ASSERT_NEVER(label, clk, rst, cond)
`define ADPCM_ASSERT_NEXT(label, clk, rst, ante, cons)
`define ADPCM_ASSERT_SAME(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/adpcm_pkg.sv
// Shared types and constants of the second-order ADPCM block decoder.
// Used by every module of the block; depends on nothing.
package adpcm_pkg;

   // Block layout: two scale bytes, then sixteen bytes of nibble pairs.
   localparam logic [4:0] BLOCK_BYTES = 5'd18;
   localparam logic [4:0] SCALE_HI_POS = 5'd0;
   localparam logic [4:0] SCALE_LO_POS = 5'd1;

   // Predictor coefficients in Q14 and the shift that removes the fraction.
   localparam logic [14:0] COEF_A = 15'h7298;
   localparam logic [13:0] COEF_B = 14'h3350;
   localparam int PRED_SHIFT = 14;

   // Saturation limits of a 16-bit sample.
   localparam logic signed [21:0] SAT_HI = 22'sd32767;
   localparam logic signed [21:0] SAT_LO = -22'sd32768;

   // Depth of the internal queues.
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // One input byte.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       channel;
   } req_type;

   // One decoded sample.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               sample_channel;
      logic               last;
   } rsp_type;

   // A data byte handed from the front to the back, with its block scale.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        channel;
      logic [15:0] scale;
   } work_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      B_IDLE,
      B_MULT,
      B_SUM
   } back_state_type;

endpackage

>>> rtl/second_order_adpcm_block_decoder.sv
// Second-order ADPCM block decoder. Each channel receives 18-byte blocks, one
// byte per input transfer: two scale bytes that give no result, then sixteen
// data bytes that each give two samples, high nibble first. A scale byte or a
// byte for a channel at or above CHANNELS is absorbed by the front end. A data
// byte is decoded in the back end one nibble at a time: each nibble passes a
// multiply state and an accumulate state, and the second nibble depends on the
// first through the predictor history. A two-entry queue between front and
// back, and a two-entry result queue, let input and output stall on their own.
// Depends on adpcm_pkg, adpcm_queue, adpcm_front, adpcm_back and the macro header.
`include "second_order_adpcm_block_decoder_macros.svh"

module second_order_adpcm_block_decoder #(
   parameter int CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  adpcm_pkg::req_type req_payload,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output adpcm_pkg::rsp_type rsp_payload
);

   adpcm_pkg::work_type work_wr, work_rd;
   adpcm_pkg::rsp_type  out_wr;
   logic work_push, work_full, work_pop, work_empty;
   logic out_push, out_full;

   // Front end: block position and scale tracking.
   adpcm_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_payload(req_payload),
      .work_push(work_push),
      .work_full(work_full),
      .work_data(work_wr)
   );

   // Queue of data bytes waiting for the predictor.
   adpcm_queue #(
      .WIDTH($bits(adpcm_pkg::work_type))
   ) u_work_queue (
      .clock(clock),
      .reset(reset),
      .push(work_push),
      .full(work_full),
      .wr_data(work_wr),
      .pop(work_pop),
      .empty(work_empty),
      .rd_data(work_rd)
   );

   // Back end: predictor datapath.
   adpcm_back #(
      .CHANNELS(CHANNELS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .work_empty(work_empty),
      .work_pop(work_pop),
      .work_data(work_rd),
      .out_push(out_push),
      .out_full(out_full),
      .out_data(out_wr)
   );

   // Result queue toward the consumer.
   adpcm_queue #(
      .WIDTH($bits(adpcm_pkg::rsp_type))
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .full(out_full),
      .wr_data(out_wr),
      .pop(rsp_pop),
      .empty(rsp_empty),
      .rd_data(rsp_payload)
   );

   // Checks on the internal queues and reset behavior.
   `ADPCM_ASSERT_NEVER(a_work_no_overflow, clock, reset, work_push && work_full)
   `ADPCM_ASSERT_NEVER(a_rsp_no_overflow, clock, reset, out_push && out_full)
   `ADPCM_ASSERT_SAME(a_pop_has_item, clock, reset, work_pop, !work_empty)
   `ADPCM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full)

endmodule

>>> rtl/adpcm_queue.sv
// Small first-in first-out queue of WIDTH-bit entries.
// Depends on adpcm_pkg for its depth.
module adpcm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [adpcm_pkg::QUEUE_DEPTH];
   logic [adpcm_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [adpcm_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [adpcm_pkg::COUNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   // Status and qualified transfers.
   assign full = (count_ff == adpcm_pkg::COUNT_W'(adpcm_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == adpcm_pkg::PTR_W'(adpcm_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == adpcm_pkg::PTR_W'(adpcm_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/adpcm_front.sv
// Front end: tracks each channel's block position, collects the scale bytes
// and forwards data bytes with their scale. Depends on adpcm_pkg.
module adpcm_front #(
   parameter int CHANNELS = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  adpcm_pkg::req_type  req_payload,
   output logic                work_push,
   input  logic                work_full,
   output adpcm_pkg::work_type work_data
);

   logic [4:0]  pos_ff   [CHANNELS];
   logic [7:0]  hi_ff    [CHANNELS];
   logic [15:0] scale_ff [CHANNELS];
   logic [4:0]  pos_sel, pos_next;
   logic [7:0]  hi_sel;
   logic [15:0] scale_sel;
   logic        ch_ok, take;

   // A byte is taken only while the work queue has room.
   assign req_full = work_full;
   assign ch_ok = (int'(req_payload.channel) < CHANNELS);
   assign take = req_push && !work_full && ch_ok;

   // Select the addressed channel's state.
   always_comb begin
      pos_sel = '0;
      hi_sel = '0;
      scale_sel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (int'(req_payload.channel) == i) begin
            pos_sel = pos_ff[i];
            hi_sel = hi_ff[i];
            scale_sel = scale_ff[i];
         end
      end
   end

   // Position wraps at the end of a block.
   assign pos_next = (pos_sel == adpcm_pkg::BLOCK_BYTES - 5'd1) ? 5'd0 : pos_sel + 5'd1;

   // Data bytes go to the back end together with the current scale.
   assign work_push = take && (pos_sel != adpcm_pkg::SCALE_HI_POS)
                      && (pos_sel != adpcm_pkg::SCALE_LO_POS);
   assign work_data.data_byte = req_payload.data_byte;
   assign work_data.channel = req_payload.channel;
   assign work_data.scale = scale_sel;

   // Per-channel position and scale registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i] <= '0;
            hi_ff[i] <= '0;
            scale_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (take && (int'(req_payload.channel) == i)) begin
               pos_ff[i] <= pos_next;
               if (pos_sel == adpcm_pkg::SCALE_HI_POS) begin
                  hi_ff[i] <= req_payload.data_byte;
               end
               if (pos_sel == adpcm_pkg::SCALE_LO_POS) begin
                  scale_ff[i] <= {hi_sel, req_payload.data_byte};
               end
            end
         end
      end
   end

endmodule

>>> rtl/adpcm_back.sv
// Back end: runs the second-order predictor on both nibbles of each data
// byte, with a multiply state and an accumulate state for each nibble.
// Depends on adpcm_pkg.
module adpcm_back #(
   parameter int CHANNELS = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_empty,
   output logic                work_pop,
   input  adpcm_pkg::work_type work_data,
   output logic                out_push,
   input  logic                out_full,
   output adpcm_pkg::rsp_type  out_data
);

   adpcm_pkg::back_state_type state_ff, state_in;
   adpcm_pkg::work_type item_ff;
   logic               nib_ff;
   logic signed [15:0] prev_ff  [CHANNELS];
   logic signed [15:0] older_ff [CHANNELS];
   logic signed [31:0] prod_a_ff, prod_a_in;
   logic signed [31:0] prod_b_ff, prod_b_in;
   logic signed [20:0] dscale_ff, dscale_in;
   logic signed [15:0] s1_sel, s2_sel;
   logic signed [3:0]  delta;
   logic signed [32:0] diff;
   logic signed [18:0] pred;
   logic signed [21:0] total;
   logic signed [15:0] sat;
   logic               load, mult_en;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         adpcm_pkg::B_IDLE: begin
            if (!work_empty) begin
               state_in = adpcm_pkg::B_MULT;
            end
         end
         adpcm_pkg::B_MULT: begin
            state_in = adpcm_pkg::B_SUM;
         end
         adpcm_pkg::B_SUM: begin
            if (!out_full) begin
               if (!nib_ff || !work_empty) begin
                  state_in = adpcm_pkg::B_MULT;
               end else begin
                  state_in = adpcm_pkg::B_IDLE;
               end
            end
         end
         default: begin
            state_in = adpcm_pkg::B_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      load = 1'b0;
      mult_en = 1'b0;
      out_push = 1'b0;
      case (state_ff)
         adpcm_pkg::B_IDLE: begin
            load = !work_empty;
         end
         adpcm_pkg::B_MULT: begin
            mult_en = 1'b1;
         end
         adpcm_pkg::B_SUM: begin
            out_push = !out_full;
            load = !out_full && nib_ff && !work_empty;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign work_pop = load;

   // History of the channel being decoded.
   always_comb begin
      s1_sel = '0;
      s2_sel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (int'(item_ff.channel) == i) begin
            s1_sel = prev_ff[i];
            s2_sel = older_ff[i];
         end
      end
   end

   // Multiply cycle: the high nibble first, then the low one.
   assign delta = nib_ff ? signed'(item_ff.data_byte[3:0]) : signed'(item_ff.data_byte[7:4]);
   assign prod_a_in = s1_sel * signed'({1'b0, adpcm_pkg::COEF_A});
   assign prod_b_in = s2_sel * signed'({1'b0, adpcm_pkg::COEF_B});
   assign dscale_in = delta * signed'({1'b0, item_ff.scale});

   // Accumulate cycle: floored shift of the prediction, add, saturate.
   assign diff = prod_a_ff - prod_b_ff;
   assign pred = signed'(diff[32:adpcm_pkg::PRED_SHIFT]);
   assign total = pred + dscale_ff;
   always_comb begin
      if (total > adpcm_pkg::SAT_HI) begin
         sat = 16'sh7FFF;
      end else if (total < adpcm_pkg::SAT_LO) begin
         sat = -16'sh8000;
      end else begin
         sat = total[15:0];
      end
   end

   assign out_data.sample = sat;
   assign out_data.sample_channel = item_ff.channel;
   assign out_data.last = nib_ff;

   // Control and history registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adpcm_pkg::B_IDLE;
         nib_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            prev_ff[i] <= '0;
            older_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load) begin
            nib_ff <= 1'b0;
         end else if (out_push) begin
            nib_ff <= 1'b1;
         end
         for (int i = 0; i < CHANNELS; i++) begin
            if (out_push && (int'(item_ff.channel) == i)) begin
               older_ff[i] <= prev_ff[i];
               prev_ff[i] <= sat;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= work_data;
      end
      if (mult_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         dscale_ff <= dscale_in;
      end
   end

endmodule
